/* hw/rtl/assert_macros.svh */
// Assertion macros used by the SHA-1 back end (sha1_back)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the cycle after
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sha1_pkg.sv */
// Package with types, constants and functions for the SHA-1 digest block
package sha1_pkg;

    localparam int QueueDepth = 4;

    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    // One queue entry: a byte for the block, and a flag for the back end
    typedef struct packed {
        logic [7:0] data;
        logic       last;   // final byte of the message, padding included
    } sha1_beat_t;

    typedef enum logic [1:0] {
        FE_MSG,
        FE_PAD,
        FE_LEN
    } sha1_fe_state_t;

    typedef enum logic [2:0] {
        BE_LOAD,
        BE_ROUND,
        BE_ADD,
        BE_OUT
    } sha1_be_state_t;

    function automatic logic [31:0] sha1_k(input logic [6:0] t);
        logic [31:0] k;
        if (t < 7'd20)
            k = 32'h5a827999;
        else if (t < 7'd40)
            k = 32'h6ed9eba1;
        else if (t < 7'd60)
            k = 32'h8f1bbcdc;
        else
            k = 32'hca62c1d6;
        return k;
    endfunction

    function automatic logic [31:0] sha1_f(input logic [6:0] t, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (t < 7'd20)
            f = (b & c) ^ (~b & d);
        else if (t < 7'd40 || t >= 7'd60)
            f = b ^ c ^ d;
        else
            f = (b & c) ^ (b & d) ^ (c & d);
        return f;
    endfunction

endpackage

/* hw/rtl/sha1_front.sv */
// Front end: counts message bytes and inserts padding and length bytes
module sha1_front
    import sha1_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       q_valid,
    input  logic       q_ready,
    output sha1_beat_t q_beat
);

    sha1_fe_state_t state_reg, state_next;
    logic [60:0]    len_reg, len_next;
    logic [5:0]     pos_reg, pos_next;
    logic [2:0]     lidx_reg, lidx_next;
    logic [63:0]    bits;

    assign bits = {len_reg, 3'b000};

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        lidx_next  = lidx_reg;
        case (state_reg)
            FE_MSG:
            begin
                if (in_valid && q_ready)
                begin
                    len_next = len_reg + 61'd1;
                    pos_next = pos_reg + 6'd1;
                    if (in_last)
                        state_next = FE_PAD;
                end
            end
            FE_PAD:
            begin
                if (q_ready)
                begin
                    pos_next = pos_reg + 6'd1;
                    if (pos_reg == 6'd55)
                    begin
                        state_next = FE_LEN;
                        lidx_next  = 3'd0;
                    end
                end
            end
            FE_LEN:
            begin
                if (q_ready)
                begin
                    lidx_next = lidx_reg + 3'd1;
                    if (lidx_reg == 3'd7)
                    begin
                        state_next = FE_MSG;
                        len_next   = '0;
                        pos_next   = '0;
                    end
                end
            end
            default: state_next = FE_MSG;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        q_valid     = 1'b0;
        q_beat.data = 8'h00;
        q_beat.last = 1'b0;
        case (state_reg)
            FE_MSG:
            begin
                in_ready    = q_ready;
                q_valid     = in_valid;
                q_beat.data = in_byte;
            end
            FE_PAD:
            begin
                q_valid = 1'b1;
                // first pad byte carries the marker bit
                q_beat.data = (pos_reg == len_reg[5:0]) ? 8'h80 : 8'h00;
            end
            FE_LEN:
            begin
                q_valid     = 1'b1;
                q_beat.data = bits[8*(7-lidx_reg) +: 8];
                q_beat.last = (lidx_reg == 3'd7);
            end
            default: q_valid = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FE_MSG;
            len_reg   <= '0;
            pos_reg   <= '0;
            lidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            lidx_reg  <= lidx_next;
        end
    end

endmodule

/* hw/rtl/sha1_queue.sv */
// Short FIFO between the front end and the compression back end
module sha1_queue
    import sha1_pkg::*;
#(
    parameter int DEPTH = QueueDepth
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_valid,
    output logic       wr_ready,
    input  sha1_beat_t wr_beat,
    output logic       rd_valid,
    input  logic       rd_ready,
    output sha1_beat_t rd_beat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha1_beat_t       mem_reg [DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;
    logic             wr_en, rd_en;

    assign wr_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_beat  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_beat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + AW'(1);
            if (rd_en)
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

endmodule

/* hw/rtl/sha1_back.sv */
// Back end: packs bytes into the schedule, runs 80 rounds, emits the digest
module sha1_back
    import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  sha1_beat_t  q_beat,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_word,
    output logic [2:0]  out_index,
    output logic        out_last
);
`include "assert_macros.svh"

    sha1_be_state_t state_reg, state_next;
    logic [31:0] w_reg [16];
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] pack_reg;
    logic [5:0]  pos_reg;
    logic [6:0]  t_reg;
    logic        fin_reg;
    logic [2:0]  oidx_reg;
    logic        take;
    logic [31:0] pack_next, wx, wt, tmp;
    logic [3:0]  ti;

    assign take      = (state_reg == BE_LOAD) && q_valid;
    assign q_ready   = (state_reg == BE_LOAD);
    assign pack_next = {pack_reg[23:0], q_beat.data};
    assign ti        = t_reg[3:0];
    assign wx        = w_reg[ti - 4'd3] ^ w_reg[ti - 4'd8] ^ w_reg[ti - 4'd14] ^ w_reg[ti];
    assign wt        = (t_reg < 7'd16) ? w_reg[ti] : {wx[30:0], wx[31]};
    assign tmp       = {a_reg[26:0], a_reg[31:27]} + sha1_f(t_reg, b_reg, c_reg, d_reg)
                       + e_reg + sha1_k(t_reg) + wt;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BE_LOAD:  if (take && pos_reg == 6'd63) state_next = BE_ROUND;
            BE_ROUND: if (t_reg == 7'd79) state_next = BE_ADD;
            BE_ADD:   state_next = fin_reg ? BE_OUT : BE_LOAD;
            BE_OUT:   if (out_ready && oidx_reg == 3'd4) state_next = BE_LOAD;
            default:  state_next = BE_LOAD;
        endcase
    end

    always_comb
    begin
        out_valid = (state_reg == BE_OUT);
        out_word  = h_reg[oidx_reg];
        out_index = oidx_reg;
        out_last  = (oidx_reg == 3'd4);
    end

    // schedule window and working variables hold no reset
    always_ff @(posedge clk)
    begin
        if (take && pos_reg[1:0] == 2'd3)
            w_reg[pos_reg[5:2]] <= pack_next;
        if (state_reg == BE_ROUND)
        begin
            w_reg[ti] <= wt;
            a_reg <= tmp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        else if (take && pos_reg == 6'd63)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BE_LOAD;
            h_reg     <= H_INIT;
            pack_reg  <= '0;
            pos_reg   <= '0;
            t_reg     <= '0;
            fin_reg   <= 1'b0;
            oidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (take)
            begin
                pack_reg <= pack_next;
                pos_reg  <= pos_reg + 6'd1;
                fin_reg  <= q_beat.last;
            end
            if (state_reg == BE_ROUND)
                t_reg <= (t_reg == 7'd79) ? 7'd0 : t_reg + 7'd1;
            if (state_reg == BE_ADD)
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
            end
            if (state_reg == BE_OUT && out_ready)
            begin
                oidx_reg <= (oidx_reg == 3'd4) ? 3'd0 : oidx_reg + 3'd1;
                if (oidx_reg == 3'd4)
                begin
                    h_reg    <= H_INIT;
                    pack_reg <= '0;
                end
            end
        end
    end

    `ASSERT_IMPLY(a_round_cnt, clk, rst_n, state_reg != BE_ROUND, t_reg == 7'd0, "round count off")
    `ASSERT_NEXT(a_full_block, clk, rst_n, take && pos_reg == 6'd63, state_reg == BE_ROUND, "no compress")
    `ASSERT_IMPLY(a_out_pos, clk, rst_n, state_reg == BE_OUT, pos_reg == 6'd0, "digest mid block")

endmodule

/* hw/rtl/sha1_message_digest.sv */
// SHA-1 digest block: takes message bytes, returns five digest words
// Usage:
//  Slave stream: s_axis_tdata[7:0] carries one message byte, s_axis_tlast
//  marks the final byte of a message. Master stream: m_axis_tdata[31:0] is a
//  digest word, [34:32] its index (0 = H0), m_axis_tlast flags the fifth word.
//  A front end counts bytes and, after the final byte, inserts the 0x80 byte,
//  zero bytes and the 64-bit bit length; a four-entry queue carries the bytes
//  to the back end, which packs words and runs one SHA-1 round a cycle.
//  Throughput: one byte a cycle while a block loads and the queue holds bytes;
//  no byte is taken during the 80 rounds, the chaining add or the digest output,
//  so the rate is set by the single shared round unit.
//  Between the final byte and the first digest word lie the padding bytes
//  and one or two compressions, each with its chaining add.
//  The digest words are held while m_axis_tready is low; the front end keeps
//  taking bytes until the queue fills; s_axis_tready is low then and while it pads.
//  Reset (rst_n low) clears counters and restores the initial chaining value.
module sha1_message_digest
    import sha1_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepth
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast
);

    logic       fq_valid, fq_ready, qb_valid, qb_ready;
    sha1_beat_t fq_beat, qb_beat;
    logic [31:0] word;
    logic [2:0]  idx;

    sha1_front u_front (
        .clk, .rst_n,
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_beat   (fq_beat)
    );

    sha1_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk, .rst_n,
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_beat  (fq_beat),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_beat  (qb_beat)
    );

    sha1_back u_back (
        .clk, .rst_n,
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_beat    (qb_beat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (word),
        .out_index (idx),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b00000, idx, word};

endmodule
